### design/qet_pkg.sv
// Package for the quoted/escaped tokenizer: lexer mode type, configuration and
// result structs, mode codes and the escape translation function.
// No dependencies.
package qet_pkg;

   localparam int BYTE_W = 8;
   localparam int MODE_W = 3;
   localparam int CSR_INDEX_W = 3;

   // Configuration register indexes on the csr port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMENT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_A = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_B = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_C = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_D = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_E = 3'd7;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0] RST_ESCAPE  = 8'd92;  // backslash
   localparam logic [BYTE_W-1:0] RST_QUOTE   = 8'd34;  // double quote
   localparam logic [BYTE_W-1:0] RST_COMMENT = 8'd35;  // hash
   localparam logic [BYTE_W-1:0] RST_DELIM_A = 8'd32;  // space
   localparam logic [BYTE_W-1:0] RST_DELIM_B = 8'd61;  // equals sign
   localparam logic [BYTE_W-1:0] RST_DELIM_C = 8'd9;   // tab
   localparam logic [BYTE_W-1:0] RST_DELIM_D = 8'd13;  // carriage return
   localparam logic [BYTE_W-1:0] RST_DELIM_E = 8'd10;  // newline

   // Mode codes as reported on rsp_mode_after.
   localparam logic [MODE_W-1:0] MODE_CODE_NORMAL  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_ESC     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_QUOTED  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CODE_QESC    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CODE_COMMENT = 3'd4;

   // Escape letters and the control codes they stand for.
   localparam logic [BYTE_W-1:0] CHAR_N = 8'h6e;
   localparam logic [BYTE_W-1:0] CHAR_T = 8'h74;
   localparam logic [BYTE_W-1:0] CHAR_V = 8'h76;
   localparam logic [BYTE_W-1:0] CHAR_B = 8'h62;
   localparam logic [BYTE_W-1:0] CHAR_R = 8'h72;
   localparam logic [BYTE_W-1:0] CHAR_F = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
   localparam logic [BYTE_W-1:0] CTRL_LF  = 8'd10;
   localparam logic [BYTE_W-1:0] CTRL_HT  = 8'd9;
   localparam logic [BYTE_W-1:0] CTRL_VT  = 8'd11;
   localparam logic [BYTE_W-1:0] CTRL_BS  = 8'd8;
   localparam logic [BYTE_W-1:0] CTRL_CR  = 8'd13;
   localparam logic [BYTE_W-1:0] CTRL_FF  = 8'd12;
   localparam logic [BYTE_W-1:0] CTRL_BEL = 8'd7;

   typedef enum logic [4:0] {
      LEX_NORMAL  = 5'b00001,
      LEX_ESC     = 5'b00010,
      LEX_QUOTED  = 5'b00100,
      LEX_QESC    = 5'b01000,
      LEX_COMMENT = 5'b10000
   } lex_mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] escape_code;
      logic [BYTE_W-1:0] quote_code;
      logic [BYTE_W-1:0] comment_code;
      logic [BYTE_W-1:0] delim_a;
      logic [BYTE_W-1:0] delim_b;
      logic [BYTE_W-1:0] delim_c;
      logic [BYTE_W-1:0] delim_d;
      logic [BYTE_W-1:0] delim_e;
   } cfg_type;

   typedef struct packed {
      logic              end_before;
      logic              byte_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              end_after;
      logic [MODE_W-1:0] mode_after;
   } result_type;

   function automatic logic [BYTE_W-1:0] translate_escape(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      case (c)
         CHAR_N:  r = CTRL_LF;
         CHAR_T:  r = CTRL_HT;
         CHAR_V:  r = CTRL_VT;
         CHAR_B:  r = CTRL_BS;
         CHAR_R:  r = CTRL_CR;
         CHAR_F:  r = CTRL_FF;
         CHAR_A:  r = CTRL_BEL;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic [MODE_W-1:0] mode_code(input lex_mode_type m);
      logic [MODE_W-1:0] r;
      case (m)
         LEX_ESC:     r = MODE_CODE_ESC;
         LEX_QUOTED:  r = MODE_CODE_QUOTED;
         LEX_QESC:    r = MODE_CODE_QESC;
         LEX_COMMENT: r = MODE_CODE_COMMENT;
         default:     r = MODE_CODE_NORMAL;
      endcase
      return r;
   endfunction

endpackage

### design/qet_lexer.sv
// One tokenizer step: from the current mode, token-open flag and one byte,
// the next mode and flag and the result word. Depends on qet_pkg.
module qet_lexer import qet_pkg::*; (
   input  lex_mode_type      mode,
   input  logic              token_open,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              end_of_input,
   input  cfg_type           cfg,
   output lex_mode_type      mode_next,
   output logic              token_open_next,
   output result_type        result
);

   logic              end_before;
   logic              valid;
   logic [BYTE_W-1:0] ob;
   logic              open_mid;
   logic              is_delim;

   assign is_delim = (in_byte == cfg.delim_a) || (in_byte == cfg.delim_b) ||
                     (in_byte == cfg.delim_c) || (in_byte == cfg.delim_d) ||
                     (in_byte == cfg.delim_e);

   always_comb begin
      end_before = 1'b0;
      valid      = 1'b0;
      ob         = '0;
      open_mid   = token_open;
      mode_next  = mode;
      case (mode)
         LEX_ESC: begin
            ob        = translate_escape(in_byte);
            valid     = 1'b1;
            mode_next = LEX_NORMAL;
         end
         LEX_QUOTED: begin
            if (in_byte == cfg.quote_code) begin
               mode_next = LEX_NORMAL;
            end else if (in_byte == cfg.escape_code) begin
               mode_next = LEX_QESC;
            end else begin
               ob    = in_byte;
               valid = 1'b1;
            end
         end
         LEX_QESC: begin
            ob        = translate_escape(in_byte);
            valid     = 1'b1;
            mode_next = LEX_QUOTED;
         end
         LEX_COMMENT: begin
            if (in_byte == cfg.delim_e) begin
               end_before = token_open;
               open_mid   = 1'b0;
               mode_next  = LEX_NORMAL;
            end else begin
               ob    = in_byte;
               valid = 1'b1;
            end
         end
         default: begin
            // Priority order: escape, quote, comment, delimiter, plain byte.
            mode_next = LEX_NORMAL;
            if (in_byte == cfg.escape_code) begin
               mode_next = LEX_ESC;
            end else if (in_byte == cfg.quote_code) begin
               mode_next = LEX_QUOTED;
            end else if (in_byte == cfg.comment_code) begin
               end_before = token_open;
               open_mid   = 1'b0;
               ob         = in_byte;
               valid      = 1'b1;
               mode_next  = LEX_COMMENT;
            end else if (is_delim) begin
               end_before = token_open;
               open_mid   = 1'b0;
            end else begin
               ob    = in_byte;
               valid = 1'b1;
            end
         end
      endcase
   end

   logic open_after;
   assign open_after      = open_mid || valid;
   assign token_open_next = open_after && !end_of_input;

   assign result.end_before = end_before;
   assign result.byte_valid = valid;
   assign result.out_byte   = ob;
   assign result.end_after  = open_after && end_of_input;
   assign result.mode_after = mode_code(mode_next);

endmodule

### design/quoted_escaped_tokenizer.sv
// Top level of the quoted/escaped tokenizer: input register, lexer state,
// configuration registers and result register. Depends on qet_pkg, qet_lexer.
//
// The tokenizer takes one text byte per word on the req channel and returns
// exactly one result word per byte on the rsp channel, in order. It sustains
// one byte per clock while rsp_ready stays high: a byte is captured in an
// input register, run through the lexer step in the next cycle and lands in
// the result register, which drives rsp_valid and the result word. The lexer
// mode and the token-open flag are the only loop-carried state, and the
// combinational lexer step computes their next values, which is what sets the
// one-byte-per-clock figure. Backpressure on rsp stalls the input register;
// while the result register is full and rsp_ready is high, a new byte is
// still accepted in the same cycle. Configuration registers are written
// through the csr port and should only be changed while no byte is in flight.
// Modes carry across lines and across end-of-input flushes, so a quoted value
// may span several lines.
module quoted_escaped_tokenizer import qet_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_in_byte,
   input  logic                   req_end_of_input,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_end_before,
   output logic                   rsp_byte_valid,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_end_after,
   output logic [MODE_W-1:0]      rsp_mode_after,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata
);

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ESCAPE:  cfg_in.escape_code  = csr_wdata;
            CSR_QUOTE:   cfg_in.quote_code   = csr_wdata;
            CSR_COMMENT: cfg_in.comment_code = csr_wdata;
            CSR_DELIM_A: cfg_in.delim_a      = csr_wdata;
            CSR_DELIM_B: cfg_in.delim_b      = csr_wdata;
            CSR_DELIM_C: cfg_in.delim_c      = csr_wdata;
            CSR_DELIM_D: cfg_in.delim_d      = csr_wdata;
            CSR_DELIM_E: cfg_in.delim_e      = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_code  <= RST_ESCAPE;
         cfg_ff.quote_code   <= RST_QUOTE;
         cfg_ff.comment_code <= RST_COMMENT;
         cfg_ff.delim_a      <= RST_DELIM_A;
         cfg_ff.delim_b      <= RST_DELIM_B;
         cfg_ff.delim_c      <= RST_DELIM_C;
         cfg_ff.delim_d      <= RST_DELIM_D;
         cfg_ff.delim_e      <= RST_DELIM_E;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake. The input register moves forward whenever the result register
   // is empty or is being drained in this cycle.
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eoi_ff;
   logic              rsp_valid_ff;
   logic              advance;
   logic              req_fire;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   // Lexer state and step.
   lex_mode_type mode_ff, mode_in;
   logic         open_ff, open_in;
   result_type   step_result;
   result_type   rsp_ff;

   qet_lexer u_lexer (
      .mode            (mode_ff),
      .token_open      (open_ff),
      .in_byte         (in_byte_ff),
      .end_of_input    (in_eoi_ff),
      .cfg             (cfg_ff),
      .mode_next       (mode_in),
      .token_open_next (open_in),
      .result          (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= LEX_NORMAL;
         open_ff <= 1'b0;
      end else if (advance) begin
         mode_ff <= mode_in;
         open_ff <= open_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_end_before = rsp_ff.end_before;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_end_after  = rsp_ff.end_after;
   assign rsp_mode_after = rsp_ff.mode_after;

endmodule

### design/qet_checker.sv
// Port-level checks for the quoted/escaped tokenizer, bound to the top level.
// Depends on qet_pkg and quoted_escaped_tokenizer.
module qet_checker import qet_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_end_before,
   input logic                   rsp_byte_valid,
   input logic [BYTE_W-1:0]      rsp_out_byte,
   input logic                   rsp_end_after,
   input logic [MODE_W-1:0]      rsp_mode_after
);

   // A word that carries no token byte shows a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == '0)
      else $error("out_byte not zero without byte_valid");

   // Only the comment character both ends a token and appends a byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_before && rsp_byte_valid |-> rsp_mode_after == MODE_CODE_COMMENT)
      else $error("end_before with a byte outside a comment start");

   // A token that ends before a byte cannot also end after it unless a byte opened one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_after |-> rsp_byte_valid || !rsp_end_before)
      else $error("end_after with no open token");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_mode_after) && $stable(rsp_byte_valid))
      else $error("stalled result changed");

endmodule

bind quoted_escaped_tokenizer qet_checker u_qet_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for quoted_escaped_tokenizer: directed and random text streams,
// with every result checked against a byte-level lexer predictor held in this file.
// Depends on qet_pkg and the quoted_escaped_tokenizer RTL.
module tb;
   import qet_pkg::*;

   // The run ends here at the latest.
   localparam int CYCLE_LIMIT = 200000;
   // Settle time after the last expected result, so that a stray result can show up.
   localparam int SETTLE_CYCLES = 4;
   localparam logic [BYTE_W-1:0] QUESTION_MARK = 8'h3f;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_in_byte = '0;
   logic                   req_end_of_input = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_end_before;
   logic                   rsp_byte_valid;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_end_after;
   logic [MODE_W-1:0]      rsp_mode_after;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ESCAPE;
   logic [BYTE_W-1:0]      csr_wdata = '0;

   // Lexer predictor state. It mirrors the block's registers and loop-carried state.
   cfg_type           lex_cfg;
   logic [MODE_W-1:0] lex_state;
   logic              token_live;
   result_type        predicted_results[$];

   int error_count = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   // Idle rates in percent per cycle for the sender and the receiver.
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   // A long receiver hold-off, counted down by the receiver process.
   int rsp_hold_cycles = 0;

   quoted_escaped_tokenizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_end_before   (rsp_end_before),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_after    (rsp_end_after),
      .rsp_mode_after   (rsp_mode_after),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Backslash sequences: the seven letters become control codes, and any other byte
   // stands for itself.
   function automatic logic [BYTE_W-1:0] unescape(input logic [BYTE_W-1:0] c);
      case (c)
         CHAR_N:  return CTRL_LF;
         CHAR_T:  return CTRL_HT;
         CHAR_V:  return CTRL_VT;
         CHAR_B:  return CTRL_BS;
         CHAR_R:  return CTRL_CR;
         CHAR_F:  return CTRL_FF;
         CHAR_A:  return CTRL_BEL;
         default: return c;
      endcase
   endfunction

   function automatic logic is_delimiter(input logic [BYTE_W-1:0] c);
      return c == lex_cfg.delim_a || c == lex_cfg.delim_b || c == lex_cfg.delim_c ||
             c == lex_cfg.delim_d || c == lex_cfg.delim_e;
   endfunction

   // Advances the predictor by one text byte and returns the result word the block
   // must produce for it.
   function automatic result_type tokenize_byte(input logic [BYTE_W-1:0] c, input logic eoi);
      result_type r;
      r = '0;
      case (lex_state)
         MODE_CODE_ESC: begin
            r.out_byte = unescape(c);
            r.byte_valid = 1'b1;
            lex_state = MODE_CODE_NORMAL;
         end
         MODE_CODE_QUOTED: begin
            // Inside quotes, delimiters and the comment byte are plain text.
            if (c == lex_cfg.quote_code) begin
               lex_state = MODE_CODE_NORMAL;
            end else if (c == lex_cfg.escape_code) begin
               lex_state = MODE_CODE_QESC;
            end else begin
               r.out_byte = c;
               r.byte_valid = 1'b1;
            end
         end
         MODE_CODE_QESC: begin
            r.out_byte = unescape(c);
            r.byte_valid = 1'b1;
            lex_state = MODE_CODE_QUOTED;
         end
         MODE_CODE_COMMENT: begin
            // Only the newline byte ends a comment. It is not part of the token.
            if (c == lex_cfg.delim_e) begin
               r.end_before = token_live;
               token_live = 1'b0;
               lex_state = MODE_CODE_NORMAL;
            end else begin
               r.out_byte = c;
               r.byte_valid = 1'b1;
            end
         end
         default: begin
            // Normal mode, and the unused codes. Registers that hold the same byte are
            // resolved in this order: escape, quote, comment, delimiter.
            if (c == lex_cfg.escape_code) begin
               lex_state = MODE_CODE_ESC;
            end else if (c == lex_cfg.quote_code) begin
               lex_state = MODE_CODE_QUOTED;
            end else if (c == lex_cfg.comment_code) begin
               r.end_before = token_live;
               token_live = 1'b0;
               r.out_byte = c;
               r.byte_valid = 1'b1;
               lex_state = MODE_CODE_COMMENT;
            end else if (is_delimiter(c)) begin
               r.end_before = token_live;
               token_live = 1'b0;
            end else begin
               r.out_byte = c;
               r.byte_valid = 1'b1;
            end
         end
      endcase
      // A token only exists once a byte has been appended, so empty tokens never end.
      if (r.byte_valid) begin
         token_live = 1'b1;
      end
      // End of input flushes an open token but leaves the mode as it is.
      if (eoi && token_live) begin
         r.end_after = 1'b1;
         token_live = 1'b0;
      end
      r.mode_after = lex_state;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // The monitor samples at the rising edge. The testbench drives inputs at the falling
   // edge, so every value seen here is the one that the block sees at that edge.
   // Results are checked before new predictions are queued. This keeps the queue in order
   // when a byte is accepted and a result leaves at the same edge.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         lex_cfg = '{RST_ESCAPE, RST_QUOTE, RST_COMMENT, RST_DELIM_A, RST_DELIM_B,
                     RST_DELIM_C, RST_DELIM_D, RST_DELIM_E};
         lex_state = MODE_CODE_NORMAL;
         token_live = 1'b0;
         predicted_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               report_mismatch("result word with nothing expected", rsp_out_byte, 0);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_end_before !== want.end_before)
                  report_mismatch("end_before", rsp_end_before, want.end_before);
               if (rsp_byte_valid !== want.byte_valid)
                  report_mismatch("byte_valid", rsp_byte_valid, want.byte_valid);
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, want.out_byte);
               if (rsp_end_after !== want.end_after)
                  report_mismatch("end_after", rsp_end_after, want.end_after);
               if (rsp_mode_after !== want.mode_after)
                  report_mismatch("mode_after", rsp_mode_after, want.mode_after);
            end
         end
         if (req_valid && req_ready) begin
            predicted_results = {predicted_results,
                                 tokenize_byte(req_in_byte, req_end_of_input)};
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ESCAPE:  lex_cfg.escape_code = csr_wdata;
               CSR_QUOTE:   lex_cfg.quote_code = csr_wdata;
               CSR_COMMENT: lex_cfg.comment_code = csr_wdata;
               CSR_DELIM_A: lex_cfg.delim_a = csr_wdata;
               CSR_DELIM_B: lex_cfg.delim_b = csr_wdata;
               CSR_DELIM_C: lex_cfg.delim_c = csr_wdata;
               CSR_DELIM_D: lex_cfg.delim_d = csr_wdata;
               default:     lex_cfg.delim_e = csr_wdata;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, predicted_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver. A pending hold-off takes priority over the random idle rate.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready = 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offers one word and returns at the falling edge after it is accepted. Valid stays
   // high on return, so back-to-back words need no gap. Idle cycles and drains lower it.
   task automatic send_byte(input logic [BYTE_W-1:0] c, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_byte = c;
      req_end_of_input = eoi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Random text uses end of input in roughly one word of sixteen.
   task automatic emit(input logic [BYTE_W-1:0] c);
      send_byte(c, $urandom_range(15) == 0);
   endtask

   // Lowers valid and waits until every predicted result has been taken.
   task automatic drain_results();
      req_valid = 1'b0;
      while (predicted_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [BYTE_W-1:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_registers(input cfg_type v);
      drain_results();
      write_reg(CSR_ESCAPE, v.escape_code);
      write_reg(CSR_QUOTE, v.quote_code);
      write_reg(CSR_COMMENT, v.comment_code);
      write_reg(CSR_DELIM_A, v.delim_a);
      write_reg(CSR_DELIM_B, v.delim_b);
      write_reg(CSR_DELIM_C, v.delim_c);
      write_reg(CSR_DELIM_D, v.delim_d);
      write_reg(CSR_DELIM_E, v.delim_e);
   endtask

   function automatic logic [BYTE_W-1:0] any_delimiter();
      case ($urandom_range(4))
         0:       return lex_cfg.delim_a;
         1:       return lex_cfg.delim_b;
         2:       return lex_cfg.delim_c;
         3:       return lex_cfg.delim_d;
         default: return lex_cfg.delim_e;
      endcase
   endfunction

   // The byte after an escape: mostly the translated letters, with '?' and
   // arbitrary bytes mixed in.
   function automatic logic [BYTE_W-1:0] escape_letter();
      case ($urandom_range(8))
         0:       return CHAR_N;
         1:       return CHAR_T;
         2:       return CHAR_V;
         3:       return CHAR_B;
         4:       return CHAR_R;
         5:       return CHAR_F;
         6:       return CHAR_A;
         7:       return QUESTION_MARK;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] word_byte();
      if ($urandom_range(3) == 0) begin
         return 8'($urandom_range(255));
      end
      return 8'($urandom_range(8'h7a, 8'h61));
   endfunction

   // Sends configuration-like text built from the current register values: words,
   // delimiters, quoted values with escapes, comments and line ends. About one pick in
   // five is a raw byte, which breaks sequences at random places.
   task automatic send_text(input int n_bytes);
      int stop;
      int len;
      stop = bytes_sent + n_bytes;
      while (bytes_sent < stop) begin
         case ($urandom_range(9))
            0, 1: begin
               len = $urandom_range(1, 6);
               repeat (len) emit(word_byte());
            end
            2: begin
               emit(any_delimiter());
            end
            3, 4: begin
               emit(lex_cfg.quote_code);
               len = $urandom_range(0, 5);
               repeat (len) begin
                  case ($urandom_range(3))
                     0: emit(any_delimiter());
                     1: begin
                        emit(lex_cfg.escape_code);
                        emit(escape_letter());
                     end
                     default: emit(word_byte());
                  endcase
               end
               emit(lex_cfg.quote_code);
            end
            5: begin
               emit(lex_cfg.escape_code);
               emit(escape_letter());
            end
            6: begin
               emit(lex_cfg.comment_code);
               len = $urandom_range(0, 5);
               repeat (len) emit(($urandom_range(3) == 0) ? any_delimiter() : word_byte());
               emit(lex_cfg.delim_e);
            end
            7: begin
               emit(lex_cfg.delim_d);
               emit(lex_cfg.delim_e);
            end
            default: begin
               emit(8'($urandom_range(255)));
            end
         endcase
      end
   endtask

   // Directed text under the reset register values. It covers the byte extremes, each
   // escape path, empty quotes, delimiters inside quotes, a comment, end-of-input flushes
   // with and without an open token, and a quoted value carried across flushes.
   task automatic test_directed();
      send_byte(CHAR_A, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(RST_DELIM_A, 1'b0);        // ends the two-byte token
      send_byte(RST_ESCAPE, 1'b0);
      send_byte(CHAR_N, 1'b0);             // becomes a newline control code
      send_byte(RST_ESCAPE, 1'b0);
      send_byte(CHAR_T, 1'b0);
      send_byte(RST_ESCAPE, 1'b0);
      send_byte(QUESTION_MARK, 1'b0);      // passes through unchanged
      send_byte(RST_DELIM_B, 1'b0);
      send_byte(RST_QUOTE, 1'b0);          // empty quotes open no token,
      send_byte(RST_QUOTE, 1'b0);
      send_byte(RST_DELIM_C, 1'b0);        // so this delimiter ends nothing
      send_byte(RST_QUOTE, 1'b0);
      send_byte(RST_DELIM_A, 1'b0);        // a space inside quotes is kept
      send_byte(RST_ESCAPE, 1'b0);
      send_byte(CHAR_V, 1'b0);
      send_byte(RST_QUOTE, 1'b0);
      send_byte(RST_COMMENT, 1'b0);        // ends the quoted token and starts a comment
      send_byte(8'h00, 1'b0);
      send_byte(RST_DELIM_E, 1'b0);        // newline ends the comment
      send_byte("x", 1'b1);                // flush with a token open
      send_byte(RST_DELIM_D, 1'b1);        // flush with nothing open
      send_byte(RST_QUOTE, 1'b1);          // quoted mode survives the flushes
      send_byte(RST_ESCAPE, 1'b1);
      send_byte(CHAR_B, 1'b1);
      send_byte(RST_QUOTE, 1'b0);
      drain_results();
   endtask

   // Several register settings. They include all-zero and all-ones, where the
   // escape byte shadows every other register, and settings with overlapping values.
   task automatic test_register_settings();
      cfg_type v;
      load_registers('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_text(70);
      load_registers('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
      send_text(70);
      repeat (2) begin
         v.escape_code = 8'($urandom_range(255));
         v.quote_code = 8'($urandom_range(255));
         v.comment_code = 8'($urandom_range(255));
         v.delim_a = 8'($urandom_range(255));
         v.delim_b = 8'($urandom_range(255));
         v.delim_c = 8'($urandom_range(255));
         v.delim_d = 8'($urandom_range(255));
         v.delim_e = 8'($urandom_range(255));
         load_registers(v);
         send_text(70);
      end
      // The quote shadows the comment and a delimiter. The escape byte equals the
      // newline, so in normal mode it starts an escape, but it still closes comments.
      load_registers('{8'h0a, 8'h22, 8'h22, 8'h22, 8'h00, 8'hff, 8'h0d, 8'h0a});
      send_text(70);
      load_registers('{RST_ESCAPE, RST_QUOTE, RST_COMMENT, RST_DELIM_A, RST_DELIM_B,
                       RST_DELIM_C, RST_DELIM_D, RST_DELIM_E});
      send_text(70);
      drain_results();
   endtask

   // The bulk of the random text under the three idle profiles.
   task automatic test_random_text();
      send_idle_pct = 13;
      rsp_idle_pct = 69;
      send_text(300);
      send_idle_pct = 69;
      rsp_idle_pct = 13;
      send_text(300);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      send_text(300);
      drain_results();
   endtask

   // The receiver stops for a long stretch while the sender keeps offering words. The
   // pipeline fills, req_ready must drop, and nothing may be lost or duplicated when the
   // receiver resumes.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_cycles = 100;
      send_text(40);
      drain_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 13;
      rsp_idle_pct = 69;
      test_directed();
      test_register_settings();
      test_random_text();
      test_backpressure();
      drain_results();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
